### hw/rtl/pathhash_pkg.sv
// Types, constants and mixing functions for the path hash block.
// Used by pathhash_mix and path_one_at_a_time_hash; no dependencies.
package pathhash_pkg;

  // Item kinds carried on s_tuser
  localparam logic [1:0] KIND_SEGMENT = 2'd0;
  localparam logic [1:0] KIND_ASN     = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;

  localparam int unsigned HASH_W  = 32;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned INDEX_W = 31;
  localparam int unsigned LOG2_W  = 5;

  // Register map (byte addresses)
  localparam logic [2:0] ADDR_TABLE_SIZE_LOG2 = 3'd0;
  localparam logic [LOG2_W-1:0] TABLE_SIZE_LOG2_RESET = 5'd16;

  typedef logic [HASH_W-1:0] hash_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
  } item_t;

  // One mixing round: h += x; h += h << 10; h ^= h >> 6
  function automatic hash_t mix_in(input hash_t h, input hash_t x);
    hash_t t;
    t = h + x;
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  // Final avalanche: h += h << 3; h ^= h >> 11; h += h << 15
  function automatic hash_t avalanche(input hash_t h);
    hash_t t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

### hw/rtl/path_one_at_a_time_hash.sv
// Path hash block: one-at-a-time hash over a stream of path items.
// Depends on pathhash_pkg and pathhash_mix.
//
// Input stream (s_*): one item per transfer. s_tuser carries the kind
// (segment type, AS number, finish only), s_tdata the 16-bit value, and
// s_tlast ends the path. Items without tlast produce no output.
// Output stream (m_*): one 31-bit hash index per path, on m_tdata.
// APB port: register table_size_log2 at address 0 masks the result to
// 2^table_size_log2; write it only while no path is in flight.
//
// Throughput: one item per cycle while s_tready is high. The item is
// registered, then mixed into the running hash; a last item's mixed hash is
// held in the finalize stage and then finalized into the output register,
// which raises m_tvalid.
// When the receiver stalls, the output register holds its result, the
// finalize stage keeps one more, and non-last items keep flowing; s_tready
// drops only when a last item cannot move on.
// Reset clears the running hash, all valid flags and sets
// table_size_log2 to 16.
module path_one_at_a_time_hash (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic [1:0]  s_tuser,   // [1:0] kind
  input  logic        s_tlast,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [30:0] hash_index, [31] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pathhash_pkg::*;

  logic [LOG2_W-1:0]  table_size_log2;
  hash_t              running_hash;
  logic               in_valid;
  item_t              in_item;
  logic               in_last;
  logic               fin_valid;
  hash_t              fin_hash;
  hash_t              mixed;
  hash_t              final_hash;
  hash_t              mask;
  logic               out_free;
  logic               fin_free;
  logic               fin_move;
  logic               in_move;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TABLE_SIZE_LOG2) ?
                  {{(32-LOG2_W){1'b0}}, table_size_log2} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size_log2 <= TABLE_SIZE_LOG2_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ADDR_TABLE_SIZE_LOG2) begin
      table_size_log2 <= pwdata[LOG2_W-1:0];
    end
  end

  // Stage flow control
  assign out_free = !m_tvalid || m_tready;
  assign fin_move = fin_valid && out_free;
  assign fin_free = !fin_valid || out_free;
  assign in_move  = in_valid && (!in_last || fin_free);
  assign s_tready = !in_valid || in_move;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind  <= s_tuser;
      in_item.value <= s_tdata;
      in_last       <= s_tlast;
    end
  end

  // Mix the item into the running hash
  pathhash_mix u_mix (
    .item     (in_item),
    .hash_in  (running_hash),
    .hash_out (mixed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (in_move) begin
      running_hash <= in_last ? '0 : mixed;
    end
  end

  // Finalize stage: holds the mixed hash of a path's last item
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (in_move && in_last) begin
      fin_valid <= 1'b1;
    end else if (fin_move) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move && in_last) begin
      fin_hash <= mixed;
    end
  end

  // Avalanche and mask into the output register
  assign final_hash = avalanche(fin_hash);
  assign mask       = (hash_t'(1) << table_size_log2) - hash_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      m_tdata <= {1'b0, final_hash[INDEX_W-1:0] & mask[INDEX_W-1:0]};
    end
  end

endmodule

### hw/rtl/pathhash_mix.sv
// Mixes one path item into the running hash (combinational).
// Depends on pathhash_pkg.
module pathhash_mix (
  input  pathhash_pkg::item_t item,
  input  pathhash_pkg::hash_t hash_in,
  output pathhash_pkg::hash_t hash_out
);
  import pathhash_pkg::*;

  // Segment: one round with the type code; AS number: low byte then high byte
  always_comb begin
    case (item.kind)
      KIND_SEGMENT: begin
        hash_out = mix_in(hash_in, {{(HASH_W-VALUE_W){1'b0}}, item.value});
      end
      KIND_ASN: begin
        hash_out = mix_in(mix_in(hash_in, {{(HASH_W-8){1'b0}}, item.value[7:0]}),
                          {{(HASH_W-8){1'b0}}, item.value[VALUE_W-1:8]});
      end
      default: begin
        hash_out = hash_in;
      end
    endcase
  end

endmodule
